>>> design/humidity_temp_frame_decoder_top_defines.svh
// Assertion macros for the sensor frame decoder.
// Included by the top level; depends on nothing else.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HTFD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HTFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/htfd_pkg.sv
// Shared types, constants and functions of the sensor frame decoder.
// No dependencies; imported by htfd_frame, htfd_scale and the top level.
`default_nettype none

package htfd_pkg;

    // frame byte positions
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [1:0] ST_HUM_CRC  = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int PROD_W = 31;
    localparam int QUOT_W = 15;

    localparam logic [PROD_W-1:0] CEL_MULT = 31'd17500;
    localparam logic [PROD_W-1:0] FAH_MULT = 31'd31500;
    localparam logic [PROD_W-1:0] HUM_MULT = 31'd10000;

    localparam logic [14:0] CEL_OFFSET = 15'd4500;
    localparam logic [15:0] FAH_OFFSET = 16'd4900;

    localparam int OUT_W = 80;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } frame_rec_t;

    // one CRC-8 byte step, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // floor(x / 65535) for x < 2^31: x = q*65536 + lo, so x = q*65535 + (lo + q)
    function automatic logic [QUOT_W-1:0] div_65535(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q;
        logic [16:0]       r;
        q = x[PROD_W-1:16];
        r = {1'b0, x[15:0]} + {2'b00, q};
        if (r >= 17'd65535) begin
            q = q + 15'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

>>> design/htfd_frame.sv
// Byte input register, frame position tracking, CRC-8 checks and frame record register.
// Depends on htfd_pkg.
`default_nettype none

module htfd_frame
    import htfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    output logic            rec_valid,
    input  wire logic       rec_ready,
    output frame_rec_t      rec
);

    logic       in_v_reg, in_v_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_start_reg, in_start_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic       temp_good_reg, temp_good_next;
    logic [7:0] hh_reg, hh_next;
    logic [7:0] hl_reg, hl_next;
    logic       rec_v_reg, rec_v_next;
    frame_rec_t rec_reg, rec_next;

    logic [2:0] pos;
    logic [7:0] crc_in;
    logic [7:0] crc_new;
    logic       is_last;
    logic       take;

    always_comb begin
        pos = pos_reg;
        if (in_start_reg || (pos_reg inside {3'd6, 3'd7})) begin
            pos = POS_T_HI;
        end
        crc_in  = (pos inside {POS_T_HI, POS_H_HI}) ? CRC_INIT : crc_reg;
        crc_new = crc8_byte(crc_in, in_byte_reg);
        is_last = (pos == POS_H_CRC);
        // a non-final byte never needs the record slot
        take     = in_v_reg && (!is_last || !rec_v_reg || rec_ready);
        s_tready = !in_v_reg || take;
    end

    always_comb begin
        in_v_next      = in_v_reg;
        in_byte_next   = in_byte_reg;
        in_start_next  = in_start_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        temp_good_next = temp_good_reg;
        hh_next        = hh_reg;
        hl_next        = hl_reg;
        rec_v_next     = rec_v_reg;
        rec_next       = rec_reg;

        if (rec_v_reg && rec_ready) begin
            rec_v_next = 1'b0;
        end
        if (take) begin
            in_v_next = 1'b0;
            crc_next  = crc_new;
            pos_next  = is_last ? POS_T_HI : pos + 3'd1;
            case (pos)
                POS_T_HI:  temp_word_next = {in_byte_reg, 8'h00};
                POS_T_LO:  temp_word_next = {temp_word_reg[15:8], in_byte_reg};
                POS_T_CRC: temp_good_next = (crc_new == 8'h00);
                POS_H_HI:  hh_next = in_byte_reg;
                POS_H_LO:  hl_next = in_byte_reg;
                default:   ;
            endcase
            if (is_last) begin
                rec_v_next         = 1'b1;
                rec_next.temp_raw  = temp_word_reg;
                rec_next.humid_raw = {hh_reg, hl_reg};
                if (!temp_good_reg) begin
                    rec_next.status = ST_TEMP_CRC;
                end else if (crc_new != 8'h00) begin
                    rec_next.status = ST_HUM_CRC;
                end else begin
                    rec_next.status = ST_OK;
                end
            end
        end
        if (s_tvalid && s_tready) begin
            in_v_next     = 1'b1;
            in_byte_next  = s_tdata;
            in_start_next = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            pos_reg   <= POS_T_HI;
            crc_reg   <= CRC_INIT;
            rec_v_reg <= 1'b0;
        end else begin
            in_v_reg  <= in_v_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            rec_v_reg <= rec_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        in_start_reg  <= in_start_next;
        temp_word_reg <= temp_word_next;
        temp_good_reg <= temp_good_next;
        hh_reg        <= hh_next;
        hl_reg        <= hl_next;
        rec_reg       <= rec_next;
    end

    assign rec_valid = rec_v_reg;
    assign rec       = rec_reg;

endmodule

`default_nettype wire

>>> design/htfd_scale.sv
// Fixed-point scaling of a frame record: constant multiply stage, then
// divide-by-65535 correction, offset and output register. Depends on htfd_pkg.
`default_nettype none

module htfd_scale
    import htfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rec_valid,
    output logic                   rec_ready,
    input  wire frame_rec_t        rec,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    logic              p_v_reg, p_v_next;
    frame_rec_t        p_rec_reg, p_rec_next;
    logic [PROD_W-1:0] p_cel_reg, p_cel_next;
    logic [PROD_W-1:0] p_fah_reg, p_fah_next;
    logic [PROD_W-1:0] p_hum_reg, p_hum_next;

    logic             o_v_reg, o_v_next;
    logic [OUT_W-1:0] o_data_reg, o_data_next;

    logic              o_ready;
    logic              p_ready;
    logic [QUOT_W-1:0] q_cel, q_fah, q_hum;
    logic [14:0]       cel;
    logic [15:0]       fah;
    logic [13:0]       hum;

    always_comb begin
        o_ready   = !o_v_reg || m_tready;
        p_ready   = !p_v_reg || o_ready;
        rec_ready = p_ready;

        q_cel = div_65535(p_cel_reg);
        q_fah = div_65535(p_fah_reg);
        q_hum = div_65535(p_hum_reg);
        cel   = q_cel - CEL_OFFSET;
        fah   = {1'b0, q_fah} - FAH_OFFSET;
        hum   = q_hum[13:0];
        // scaled values are cleared on any CRC failure
        if (p_rec_reg.status != ST_OK) begin
            cel = '0;
            fah = '0;
            hum = '0;
        end
    end

    always_comb begin
        p_v_next    = p_v_reg;
        p_rec_next  = p_rec_reg;
        p_cel_next  = p_cel_reg;
        p_fah_next  = p_fah_reg;
        p_hum_next  = p_hum_reg;
        o_v_next    = o_v_reg;
        o_data_next = o_data_reg;

        if (o_v_reg && m_tready) begin
            o_v_next = 1'b0;
        end
        if (p_v_reg && o_ready) begin
            p_v_next    = 1'b0;
            o_v_next    = 1'b1;
            o_data_next = {1'b0, hum, fah, cel, p_rec_reg.humid_raw,
                           p_rec_reg.temp_raw, p_rec_reg.status};
        end
        if (rec_valid && p_ready) begin
            p_v_next   = 1'b1;
            p_rec_next = rec;
            p_cel_next = PROD_W'(rec.temp_raw) * CEL_MULT;
            p_fah_next = PROD_W'(rec.temp_raw) * FAH_MULT;
            p_hum_next = PROD_W'(rec.humid_raw) * HUM_MULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else begin
            p_v_reg <= p_v_next;
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_rec_reg  <= p_rec_next;
        p_cel_reg  <= p_cel_next;
        p_fah_reg  <= p_fah_next;
        p_hum_reg  <= p_hum_next;
        o_data_reg <= o_data_next;
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_data_reg;

endmodule

`default_nettype wire

>>> design/humidity_temp_frame_decoder_top.sv
// Top level of the sensor frame decoder: byte framing/CRC and result scaling.
// Depends on htfd_pkg, htfd_frame, htfd_scale and the assertion macro header.
//
// Usage:
//   s_ channel carries one frame byte per item (s_tdata) with s_tuser set on
//   frame byte 0 to resynchronize. Byte order: temperature high, low, CRC,
//   humidity high, low, CRC. Without s_tuser the position wraps after byte 5.
//   m_ channel carries one result item per complete frame: status, raw words
//   and the scaled values in hundredths (zero when a CRC check fails).
//   Throughput: one byte per cycle while a finished frame has somewhere to go,
//   set by the unrolled CRC byte step in the frame stage.
//   Result path: after the edge that accepts its last byte, a frame's result moves
//   in turn through the record register, multiply register and result register.
//   Reset (aresetn low, synchronous) empties all stages and restarts the
//   frame at byte 0; any partial frame is lost.
//   A stalled m_tready fills the result, multiply and record registers in turn;
//   bytes that do not finish a frame keep being accepted until a finished
//   frame has nowhere to go, then s_tready drops.
`default_nettype none

`include "humidity_temp_frame_decoder_top_defines.svh"

module humidity_temp_frame_decoder_top
    import htfd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
    input  wire logic             s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [1:0] status, [17:2] temp_raw, [33:18] humid_raw, [48:34] celsius_centi,
    // [64:49] fahrenheit_centi, [78:65] humidity_centi, [79] zero
    output logic [OUT_W-1:0]      m_tdata
);

    logic       rec_valid;
    logic       rec_ready;
    frame_rec_t rec;

    // checker terms
    logic                        res_err;
    logic                        res_ok;
    logic                        scl_zero;
    logic                        cel_ok;
    logic                        hum_ok;
    logic                        rec_stall;
    logic [$bits(frame_rec_t):0] rec_bus;

    htfd_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    htfd_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign res_err   = m_tvalid && (m_tdata[1:0] != ST_OK);
    assign res_ok    = m_tvalid && (m_tdata[1:0] == ST_OK);
    assign scl_zero  = (m_tdata[78:34] == '0);
    assign cel_ok    = ($signed(m_tdata[48:34]) >= -15'sd4500) &&
                       ($signed(m_tdata[48:34]) <= 15'sd13000);
    assign hum_ok    = (m_tdata[78:65] <= 14'd10000);
    assign rec_stall = rec_valid && !rec_ready;
    assign rec_bus   = {rec_valid, rec};

    `HTFD_ASSERT_IMPL(a_err_zero, aclk, aresetn, res_err, scl_zero, "scaled values on CRC error")
    `HTFD_ASSERT_IMPL(a_cel_range, aclk, aresetn, res_ok, cel_ok, "celsius out of range")
    `HTFD_ASSERT_IMPL(a_hum_range, aclk, aresetn, m_tvalid, hum_ok, "humidity out of range")
    `HTFD_ASSERT_NEXT(a_rec_hold, aclk, aresetn, rec_stall, $stable(rec_bus), "record not held")

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for humidity_temp_frame_decoder_top: drives sensor frames byte by byte
// and checks each decoded reading against an in-bench frame decoder.
// Depends on htfd_pkg and the RTL of the frame decoder.
module tb;
    import htfd_pkg::*;

    localparam int RANDOM_ITEMS = 410;
    localparam int QUIET_LIMIT  = 1000;  // well above the longest sink hold-off
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        temp_raw;
        logic [15:0]        humid_raw;
        logic signed [14:0] celsius;
        logic signed [15:0] fahrenheit;
        logic [13:0]        humidity;
    } reading_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] data_byte
    logic             s_tuser;   // [0] frame_start
    logic             m_tvalid;
    logic             m_tready;
    // [1:0] status, [17:2] temp_raw, [33:18] humid_raw, [48:34] celsius_centi,
    // [64:49] fahrenheit_centi, [78:65] humidity_centi, [79] zero
    logic [OUT_W-1:0] m_tdata;

    humidity_temp_frame_decoder_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // decoder state as seen from the byte stream
    logic [2:0]  frame_pos = POS_T_HI;
    logic [7:0]  group_crc = CRC_INIT;
    logic [15:0] temp_word = '0;
    logic        temp_good = 1'b0;
    logic [7:0]  hum_hi    = '0;
    logic [7:0]  hum_lo    = '0;

    reading_t readings_due[$];
    int       mismatch_count = 0;
    int       items_sent     = 0;
    int       quiet_cycles   = 0;
    bit       src_idle       = 1'b1;
    bit       sink_idle      = 1'b1;
    int       sink_hold      = 0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // CRC-8, poly 0x31, MSB first, one data bit per iteration
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [2:0] pos;
        logic [7:0] crc;
        reading_t   r;
        longint     t;
        longint     h;
        longint     v;
        pos = start ? POS_T_HI : frame_pos;
        if (pos > POS_H_CRC) begin
            pos = POS_T_HI;
        end
        crc = crc8_step((pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : group_crc, b);
        group_crc = crc;
        case (pos)
            POS_T_HI:  temp_word = {b, 8'h00};
            POS_T_LO:  temp_word[7:0] = b;
            POS_T_CRC: temp_good = (crc == 8'h00);
            POS_H_HI:  hum_hi = b;
            POS_H_LO:  hum_lo = b;
            default: ;
        endcase
        if (pos != POS_H_CRC) begin
            frame_pos = pos + 3'd1;
        end else begin
            frame_pos   = POS_T_HI;
            r           = '0;
            r.temp_raw  = temp_word;
            r.humid_raw = {hum_hi, hum_lo};
            if (!temp_good) begin
                r.status = ST_TEMP_CRC;
            end else if (crc != 8'h00) begin
                r.status = ST_HUM_CRC;
            end else begin
                r.status = ST_OK;
            end
            // scaled values only for a clean frame
            if (r.status == ST_OK) begin
                t = temp_word;
                h = {hum_hi, hum_lo};
                v = (17500 * t) / 65535 - 4500;
                r.celsius = v[14:0];
                v = (31500 * t) / 65535 - 4900;
                r.fahrenheit = v[15:0];
                v = (10000 * h) / 65535;
                r.humidity = v[13:0];
            end
            readings_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_reading(input logic [OUT_W-1:0] d);
        reading_t e;
        if (readings_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, d);
            mismatch_count++;
        end else begin
            e = readings_due.pop_front();
            check_field("status", e.status, d[1:0]);
            check_field("temp_raw", e.temp_raw, d[17:2]);
            check_field("humid_raw", e.humid_raw, d[33:18]);
            check_field("celsius_centi", $signed(e.celsius), $signed(d[48:34]));
            check_field("fahrenheit_centi", $signed(e.fahrenheit), $signed(d[64:49]));
            check_field("humidity_centi", e.humidity, d[78:65]);
        end
    endtask

    // both handshakes observed in one place so the order per edge is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                check_reading(m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random ready delay per item while sink_idle is set, plus an optional long hold-off
    initial begin : result_sink
        int delay;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                repeat (sink_hold) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                sink_hold = 0;
            end
            delay = sink_idle ? $urandom_range(0, 15) : 0;
            repeat (delay) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int delay;
        delay = src_idle ? $urandom_range(0, 15) : 0;
        repeat (delay) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input logic bad_t, input logic bad_h, input logic start);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        logic [7:0] flip;
        t_crc = crc8_step(crc8_step(CRC_INIT, t[15:8]), t[7:0]);
        h_crc = crc8_step(crc8_step(CRC_INIT, h[15:8]), h[7:0]);
        // any nonzero flip leaves a nonzero remainder
        flip = 8'($urandom_range(1, 255));
        if (bad_t) begin
            t_crc = t_crc ^ flip;
        end
        if (bad_h) begin
            h_crc = h_crc ^ flip;
        end
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // full-scale raw words; second frame follows without a start flag
    task automatic test_extreme_frames();
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    endtask

    // partial frame dropped by a start flag, then both CRCs bad, then humidity CRC bad
    task automatic test_crc_and_resync();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'($urandom), 16'($urandom), 1'b1, 1'b1, 1'b1);
        send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b0);
    endtask

    // receiver holds off while frames stream in back to back until input stalls
    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (10) begin
            send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b1);
        end
        src_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int stop_at;
        int kind;
        int len;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                src_idle  = 1'($urandom_range(0, 1));
                sink_idle = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // stray bytes, sometimes flagged as a frame start
                len = $urandom_range(1, 5);
                repeat (len) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
            end else begin
                send_frame(pick_word(), pick_word(), kind == 3 || kind == 5,
                           kind == 4 || kind == 5, $urandom_range(0, 3) != 0);
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_extreme_frames();
        test_crc_and_resync();
        test_backpressure();
        test_random_frames();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
